// ===== hdl/fsf_pkg.sv =====
// ----------------------------------------------------------------------------
// fsf_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// four-sample frame unit.
// ----------------------------------------------------------------------------
package fsf_pkg;

  localparam int unsigned NumSamples  = 4;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned PayloadLen  = 8;
  localparam int unsigned FrameLen    = 10;
  localparam int unsigned PayloadBits = PayloadLen * 8;
  localparam int unsigned FrameBits   = FrameLen * 8;
  localparam int unsigned CntWidth    = $clog2(FrameLen);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [CntWidth-1:0] LastIdx = CntWidth'(FrameLen - 1);

  // word moving between pipeline stages
  typedef struct packed {
    logic                   valid;
    logic [PayloadBits-1:0] data;
    logic [15:0]            crc;
  } fsf_word_t;

  // reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/four_sample_frame_crc16_unit.sv =====
// ----------------------------------------------------------------------------
// four_sample_frame_crc16_unit
// Takes four 16-bit samples and emits a 10-byte frame: samples low byte
// first, then CRC-16/MODBUS of those 8 bytes, low byte first.
//
//   channel   handshake               data
//   command   start_i / busy_o        sample_a_i .. sample_d_i
//   result    frame_valid_o (strobe)  frame_byte_o, frame_last_o
//
// Eight CRC stages (one byte each) feed a byte serializer, which takes a
// frame only when idle or with the last byte of the one it sends; this
// limits sustained commands. The first byte is on the ports once a command
// has passed the CRC stages. busy_o rises while the pipeline is full.
// Reset empties the pipeline and the serializer; the receiver cannot stall.
// ----------------------------------------------------------------------------
module four_sample_frame_crc16_unit import fsf_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SampleWidth-1:0] sample_a_i,
  input  logic signed [SampleWidth-1:0] sample_b_i,
  input  logic signed [SampleWidth-1:0] sample_c_i,
  input  logic signed [SampleWidth-1:0] sample_d_i,
  output logic                          frame_valid_o,
  output logic [7:0]                    frame_byte_o,
  output logic                          frame_last_o
);

  fsf_word_t stage_w [PayloadLen+1];
  logic      stage_rdy [PayloadLen+1];

  assign stage_w[0].valid = start_i;
  assign stage_w[0].data  = {sample_d_i, sample_c_i, sample_b_i, sample_a_i};
  assign stage_w[0].crc   = CrcInit;
  assign busy_o           = !stage_rdy[0];

  for (genvar g = 0; g < PayloadLen; g++) begin : g_stage
    fsf_crc_stage #(
      .ByteIdx(g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (stage_w[g]),
      .ready_o(stage_rdy[g]),
      .ready_i(stage_rdy[g+1]),
      .word_o (stage_w[g+1])
    );
  end

  fsf_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (stage_w[PayloadLen]),
    .ready_o      (stage_rdy[PayloadLen]),
    .frame_valid_o(frame_valid_o),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o)
  );

  a_last_has_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last_o |-> frame_valid_o)
    else $error("last flag without strobe");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && !frame_last_o |=> frame_valid_o)
    else $error("gap inside a frame");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last_o |-> $past(frame_valid_o, 9) && !$past(frame_last_o, 1))
    else $error("frame shorter than ten bytes");

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> stage_w[1].valid && frame_valid_o)
    else $error("busy while pipeline has room");

endmodule

// ===== hdl/fsf_crc_stage.sv =====
// ----------------------------------------------------------------------------
// fsf_crc_stage
// One pipeline stage: folds one payload byte into the running CRC and
// carries the payload along. Holds its word while downstream stalls.
// ----------------------------------------------------------------------------
module fsf_crc_stage import fsf_pkg::*; #(
  parameter int unsigned ByteIdx = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fsf_word_t word_i,
  output logic      ready_o,
  input  logic      ready_i,
  output fsf_word_t word_o
);

  logic                   valid_q;
  logic [PayloadBits-1:0] data_q;
  logic [15:0]            crc_q;
  logic [15:0]            crc_d;

  assign ready_o = !valid_q || ready_i;
  assign crc_d   = crc_byte(word_i.crc, word_i.data[ByteIdx*8 +: 8]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && word_i.valid) begin
      data_q <= word_i.data;
      crc_q  <= crc_d;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;
  assign word_o.crc   = crc_q;

endmodule

// ===== hdl/fsf_serializer.sv =====
// ----------------------------------------------------------------------------
// fsf_serializer
// Loads a finished frame (payload plus CRC, low byte first) and shifts it
// out one byte per cycle; takes the next frame on the cycle of the last byte.
// ----------------------------------------------------------------------------
module fsf_serializer import fsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fsf_word_t  word_i,
  output logic       ready_o,
  output logic       frame_valid_o,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  logic                 active_q;
  logic [CntWidth-1:0]  count_q;
  logic [FrameBits-1:0] buf_q;
  logic                 last;
  logic                 load;

  assign last    = active_q && (count_q == LastIdx);
  assign ready_o = !active_q || last;
  assign load    = ready_o && word_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      count_q  <= '0;
    end else if (load) begin
      active_q <= 1'b1;
      count_q  <= '0;
    end else if (active_q) begin
      active_q <= !last;
      count_q  <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= {word_i.crc, word_i.data};
    end else if (active_q) begin
      buf_q <= buf_q >> 8;
    end
  end

  assign frame_valid_o = active_q;
  assign frame_byte_o  = buf_q[7:0];
  assign frame_last_o  = last;

endmodule
